### hw/rtl/tsm_pkg.sv
// Shared types, codes and the control-store program of the two-register stack machine.
// Used by every module of the block but tsm_ram; depends on nothing.
`default_nettype none

package tsm_pkg;

    // Datapath and stack sizing
    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int STK_ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int NUM_ARGS    = 4;
    localparam int ARG_IDX_W   = 2;
    localparam int CFG_IDX_W   = 8;
    localparam int FUNC_W      = 4;
    localparam int STATUS_W    = 3;
    localparam int UPC_W       = 4;
    localparam int DIV_CNT_W   = $clog2(DATA_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_W - 1);

    typedef logic [NUM_ARGS-1:0][DATA_W-1:0] arg_array_t;

    // Instruction codes
    typedef enum logic [FUNC_W-1:0] {
        OP_IM = 4'd0,
        OP_AR = 4'd1,
        OP_SW = 4'd2,
        OP_PU = 4'd3,
        OP_PO = 4'd4,
        OP_AD = 4'd5,
        OP_SU = 4'd6,
        OP_MU = 4'd7,
        OP_DI = 4'd8
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_DIV0   = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_BADARG = 3'd4
    } status_t;

    // Sequencer state
    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } seq_state_t;

    // Control word fields
    typedef enum logic [2:0] {
        CHK_NONE  = 3'd0,
        CHK_ARG   = 3'd1,
        CHK_FULL  = 3'd2,
        CHK_EMPTY = 3'd3,
        CHK_DIV0  = 3'd4
    } chk_t;

    typedef enum logic [3:0] {
        A_HOLD = 4'd0,
        A_OPND = 4'd1,
        A_ARG  = 4'd2,
        A_B    = 4'd3,
        A_RAM  = 4'd4,
        A_ADD  = 4'd5,
        A_SUB  = 4'd6,
        A_MUL  = 4'd7,
        A_DIV  = 4'd8
    } asel_t;

    typedef enum logic [1:0] {
        STK_NONE = 2'd0,
        STK_PUSH = 2'd1,
        STK_POP  = 2'd2
    } stk_t;

    typedef enum logic [1:0] {
        DIV_NONE = 2'd0,
        DIV_LOAD = 2'd1,
        DIV_STEP = 2'd2
    } divop_t;

    typedef enum logic {
        COND_NEXT     = 1'b0,
        COND_DIV_LOOP = 1'b1
    } cond_t;

    typedef struct packed {
        chk_t              chk;
        asel_t             a_sel;
        logic              b_wr;
        stk_t              stk;
        divop_t            divop;
        cond_t             cond;
        logic [UPC_W-1:0]  target;
        logic              last;
    } ctrl_t;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic fail;
        logic div_busy;
    } dp_flags_t;

    // Control-store addresses
    localparam logic [UPC_W-1:0] U_IM  = 4'd0;
    localparam logic [UPC_W-1:0] U_AR  = 4'd1;
    localparam logic [UPC_W-1:0] U_SW  = 4'd2;
    localparam logic [UPC_W-1:0] U_PU  = 4'd3;
    localparam logic [UPC_W-1:0] U_PO0 = 4'd4;
    localparam logic [UPC_W-1:0] U_PO1 = 4'd5;
    localparam logic [UPC_W-1:0] U_AD  = 4'd6;
    localparam logic [UPC_W-1:0] U_SU  = 4'd7;
    localparam logic [UPC_W-1:0] U_MU  = 4'd8;
    localparam logic [UPC_W-1:0] U_DI0 = 4'd9;
    localparam logic [UPC_W-1:0] U_DI1 = 4'd10;
    localparam logic [UPC_W-1:0] U_DI2 = 4'd11;
    localparam logic [UPC_W-1:0] U_NOP = 4'd12;

    // Map an instruction code to the start of its routine
    function automatic logic [UPC_W-1:0] entry_addr(input logic [FUNC_W-1:0] func);
        logic [UPC_W-1:0] addr;
        addr = U_NOP;
        case (func)
            OP_IM:   addr = U_IM;
            OP_AR:   addr = U_AR;
            OP_SW:   addr = U_SW;
            OP_PU:   addr = U_PU;
            OP_PO:   addr = U_PO0;
            OP_AD:   addr = U_AD;
            OP_SU:   addr = U_SU;
            OP_MU:   addr = U_MU;
            OP_DI:   addr = U_DI0;
            default: addr = U_NOP;
        endcase
        return addr;
    endfunction

    // Control store: one control word per step
    function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        w = '{chk: CHK_NONE, a_sel: A_HOLD, b_wr: 1'b0, stk: STK_NONE,
              divop: DIV_NONE, cond: COND_NEXT, target: '0, last: 1'b0};
        case (addr)
            U_IM:  begin w.a_sel = A_OPND; w.last = 1'b1; end
            U_AR:  begin w.chk = CHK_ARG; w.a_sel = A_ARG; w.last = 1'b1; end
            U_SW:  begin w.a_sel = A_B; w.b_wr = 1'b1; w.last = 1'b1; end
            U_PU:  begin w.chk = CHK_FULL; w.stk = STK_PUSH; w.last = 1'b1; end
            U_PO0: begin w.chk = CHK_EMPTY; w.stk = STK_POP; end
            U_PO1: begin w.a_sel = A_RAM; w.last = 1'b1; end
            U_AD:  begin w.a_sel = A_ADD; w.last = 1'b1; end
            U_SU:  begin w.a_sel = A_SUB; w.last = 1'b1; end
            U_MU:  begin w.a_sel = A_MUL; w.last = 1'b1; end
            U_DI0: begin w.chk = CHK_DIV0; w.divop = DIV_LOAD; end
            U_DI1: begin w.divop = DIV_STEP; w.cond = COND_DIV_LOOP; w.target = U_DI1; end
            U_DI2: begin w.a_sel = A_DIV; w.last = 1'b1; end
            default: begin w.last = 1'b1; end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/two_register_stack_machine.sv
// Top level of the two-register stack machine: stream handshakes, argument registers,
// result register. Depends on tsm_pkg; instantiates tsm_seq and tsm_datapath.
//
//  port group   dir   payload                                   accepted when
//  s_*          in    tdata: operand[31:0]; tuser: func, first   s_tvalid & s_tready
//  m_*          out   tdata: acc_value[31:0]; tuser: status       m_tvalid & m_tready
//  cfg_*        in    cfg_index: register 0..3, cfg_data: value  cfg_valid & cfg_ready
//
// An instruction is accepted, then runs its microprogram: pop adds a step for the registered
// stack RAM read, and divide runs a check-and-load step, the 32-step divide loop and a result step.
// A new request is taken once the previous program has finished, even if its result
// still waits in the output register; the final step holds until that register is free.
// Reset clears A, B, the stack pointer and the argument registers; no clearing pass.
`default_nettype none

module two_register_stack_machine (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [31:0]                      s_tdata,   // [31:0] operand
    input  wire logic [4:0]                       s_tuser,   // [3:0] func, [4] first
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [31:0]                           m_tdata,   // [31:0] acc_value
    output logic [2:0]                            m_tuser,   // [2:0] status
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [tsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    tsm_pkg::arg_array_t               args_reg;
    logic                              m_tvalid_reg;
    logic [tsm_pkg::DATA_W-1:0]        m_tdata_reg;
    tsm_pkg::status_t                  m_tuser_reg;

    logic                              start;
    logic                              busy;
    logic                              step_en;
    logic                              done;
    logic                              out_free;
    tsm_pkg::ctrl_t                    ctrl;
    tsm_pkg::dp_flags_t                flags;
    logic [tsm_pkg::DATA_W-1:0]        acc_result;
    tsm_pkg::status_t                  status_result;

    assign s_tready  = !busy;
    assign start     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    tsm_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .func     (s_tuser[tsm_pkg::FUNC_W-1:0]),
        .flags    (flags),
        .out_free (out_free),
        .ctrl     (ctrl),
        .step_en  (step_en),
        .done     (done),
        .busy     (busy)
    );

    tsm_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .first         (s_tuser[tsm_pkg::FUNC_W]),
        .operand       (s_tdata),
        .args          (args_reg),
        .ctrl          (ctrl),
        .step_en       (step_en),
        .flags         (flags),
        .acc_result    (acc_result),
        .status_result (status_result)
    );

    // Argument registers; drop writes beyond the last register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            args_reg <= '0;
        end
        else if (cfg_valid && cfg_ready
                 && (cfg_index < tsm_pkg::CFG_IDX_W'(tsm_pkg::NUM_ARGS)))
        begin
            args_reg[cfg_index[tsm_pkg::ARG_IDX_W-1:0]] <= cfg_data;
        end
    end

    // Result register: load on program end, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (done)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            m_tdata_reg <= acc_result;
            m_tuser_reg <= status_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // A taken request starts a program
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy)
        else $error("accepted request did not start the sequencer");

    // A program only ends into a free result register
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_free)
        else $error("result overwritten before it was taken");

    // A finished program shows its result
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (m_tvalid && !busy))
        else $error("finished program left no result");

endmodule

`default_nettype wire

### hw/rtl/tsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the operand stack; no dependencies.
`default_nettype none

module tsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/tsm_seq.sv
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
// Depends on tsm_pkg for the control word, flags and the control-store program.
`default_nettype none

module tsm_seq (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [tsm_pkg::FUNC_W-1:0]   func,
    input  wire tsm_pkg::dp_flags_t           flags,
    input  wire logic                         out_free,
    output tsm_pkg::ctrl_t                    ctrl,
    output logic                              step_en,
    output logic                              done,
    output logic                              busy
);

    tsm_pkg::seq_state_t          state_reg, state_next;
    logic [tsm_pkg::UPC_W-1:0]    upc_reg, upc_next;
    logic                         finishing;

    // Fetch the current control word
    assign ctrl      = tsm_pkg::ucode_rom(upc_reg);
    assign finishing = ctrl.last | flags.fail;
    assign busy      = (state_reg == tsm_pkg::SEQ_RUN);
    // Hold the final step while the result register is still occupied
    assign step_en   = busy && (!finishing || out_free);
    assign done      = step_en && finishing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsm_pkg::SEQ_IDLE;
            upc_reg   <= tsm_pkg::U_NOP;
        end
        else
        begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
        end
    end

    // Next step: dispatch on start; while running, loop, advance or return to idle at the end
    always_comb
    begin
        state_next = state_reg;
        upc_next   = upc_reg;
        unique case (state_reg)
            tsm_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = tsm_pkg::SEQ_RUN;
                    upc_next   = tsm_pkg::entry_addr(func);
                end
            end
            tsm_pkg::SEQ_RUN:
            begin
                if (step_en)
                begin
                    if (finishing)
                    begin
                        state_next = tsm_pkg::SEQ_IDLE;
                    end
                    else
                    begin
                        unique case (ctrl.cond)
                            tsm_pkg::COND_DIV_LOOP:
                                upc_next = flags.div_busy ? ctrl.target
                                                          : upc_reg + 1'b1;
                            tsm_pkg::COND_NEXT:
                                upc_next = upc_reg + 1'b1;
                        endcase
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/tsm_datapath.sv
// Datapath: registers A and B, stack pointer and stack RAM, adder, multiplier, shift divider.
// Depends on tsm_pkg and instantiates tsm_ram.
`default_nettype none

module tsm_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          first,
    input  wire logic [tsm_pkg::DATA_W-1:0]    operand,
    input  wire tsm_pkg::arg_array_t           args,
    input  wire tsm_pkg::ctrl_t                ctrl,
    input  wire logic                          step_en,
    output tsm_pkg::dp_flags_t                 flags,
    output logic [tsm_pkg::DATA_W-1:0]         acc_result,
    output tsm_pkg::status_t                   status_result
);

    localparam int W = tsm_pkg::DATA_W;

    logic [W-1:0]                   a_reg, a_next;
    logic [W-1:0]                   b_reg, b_next;
    logic [tsm_pkg::SP_W-1:0]       sp_reg, sp_next;
    logic [W-1:0]                   opnd_reg;
    logic [W-1:0]                   rem_reg, quo_reg, dvs_reg;
    logic [tsm_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           neg_reg;

    logic                           fail;
    logic                           exec;
    logic [W-1:0]                   a_exe;
    logic [W-1:0]                   product;
    logic [W:0]                     rem_sh, trial;
    logic [W-1:0]                   a_mag, b_mag;
    logic [tsm_pkg::SP_W-1:0]       sp_dec;
    logic [tsm_pkg::SP_W-1:0]       sp_rd;
    logic [W-1:0]                   ram_rdata;
    logic                           ram_we;

    // Stack storage; keep the popped word's address after the pointer moves
    assign sp_dec = sp_reg - tsm_pkg::SP_W'(1);
    assign sp_rd  = (ctrl.stk == tsm_pkg::STK_POP) ? sp_dec : sp_reg;
    assign ram_we = exec && (ctrl.stk == tsm_pkg::STK_PUSH);

    tsm_ram #(
        .WIDTH (W),
        .DEPTH (tsm_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sp_reg[tsm_pkg::STK_ADDR_W-1:0]),
        .wdata (a_reg),
        .raddr (sp_rd[tsm_pkg::STK_ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Check the step's precondition and pick the status code
    always_comb
    begin
        fail          = 1'b0;
        status_result = tsm_pkg::ST_OK;
        unique case (ctrl.chk)
            tsm_pkg::CHK_ARG:
            begin
                fail = |opnd_reg[W-1:tsm_pkg::ARG_IDX_W];
                if (fail) status_result = tsm_pkg::ST_BADARG;
            end
            tsm_pkg::CHK_FULL:
            begin
                fail = (sp_reg == tsm_pkg::SP_W'(tsm_pkg::STACK_DEPTH));
                if (fail) status_result = tsm_pkg::ST_FULL;
            end
            tsm_pkg::CHK_EMPTY:
            begin
                fail = (sp_reg == '0);
                if (fail) status_result = tsm_pkg::ST_EMPTY;
            end
            tsm_pkg::CHK_DIV0:
            begin
                fail = (b_reg == '0);
                if (fail) status_result = tsm_pkg::ST_DIV0;
            end
            tsm_pkg::CHK_NONE:
            begin
                fail = 1'b0;
            end
            default:
            begin
                fail = 1'b0;
            end
        endcase
    end

    assign exec           = step_en && !fail;
    assign flags.fail     = fail;
    assign flags.div_busy = (cnt_reg != tsm_pkg::DIV_LAST);

    // Arithmetic units
    assign product = a_reg * b_reg;
    assign rem_sh  = {rem_reg, quo_reg[W-1]};
    assign trial   = rem_sh - {1'b0, dvs_reg};
    assign a_mag   = a_reg[W-1] ? (W'(0) - a_reg) : a_reg;
    assign b_mag   = b_reg[W-1] ? (W'(0) - b_reg) : b_reg;

    // Value A takes if the step executes
    always_comb
    begin
        a_exe = a_reg;
        unique case (ctrl.a_sel)
            tsm_pkg::A_OPND: a_exe = opnd_reg;
            tsm_pkg::A_ARG:  a_exe = args[opnd_reg[tsm_pkg::ARG_IDX_W-1:0]];
            tsm_pkg::A_B:    a_exe = b_reg;
            tsm_pkg::A_RAM:  a_exe = ram_rdata;
            tsm_pkg::A_ADD:  a_exe = a_reg + b_reg;
            tsm_pkg::A_SUB:  a_exe = a_reg - b_reg;
            tsm_pkg::A_MUL:  a_exe = product;
            tsm_pkg::A_DIV:  a_exe = neg_reg ? (W'(0) - quo_reg) : quo_reg;
            tsm_pkg::A_HOLD: a_exe = a_reg;
            default:         a_exe = a_reg;
        endcase
    end

    assign acc_result = fail ? a_reg : a_exe;

    // Architectural register update
    always_comb
    begin
        a_next  = a_reg;
        b_next  = b_reg;
        sp_next = sp_reg;
        if (start)
        begin
            if (first)
            begin
                a_next  = '0;
                b_next  = '0;
                sp_next = '0;
            end
        end
        else if (exec)
        begin
            a_next = a_exe;
            if (ctrl.b_wr)
            begin
                b_next = a_reg;
            end
            unique case (ctrl.stk)
                tsm_pkg::STK_PUSH: sp_next = sp_reg + tsm_pkg::SP_W'(1);
                tsm_pkg::STK_POP:  sp_next = sp_dec;
                tsm_pkg::STK_NONE: sp_next = sp_reg;
                default:           sp_next = sp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg  <= '0;
            b_reg  <= '0;
            sp_reg <= '0;
        end
        else
        begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            sp_reg <= sp_next;
        end
    end

    // Operand capture and restoring divider, one quotient bit per step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            opnd_reg <= operand;
        end
        if (exec && (ctrl.divop == tsm_pkg::DIV_LOAD))
        begin
            rem_reg <= '0;
            quo_reg <= a_mag;
            dvs_reg <= b_mag;
            neg_reg <= a_reg[W-1] ^ b_reg[W-1];
            cnt_reg <= '0;
        end
        else if (exec && (ctrl.divop == tsm_pkg::DIV_STEP))
        begin
            rem_reg <= trial[W] ? rem_sh[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ~trial[W]};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Stack pointer never passes the depth
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= tsm_pkg::SP_W'(tsm_pkg::STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // A failed check leaves A unchanged
    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && fail && !start) |=> $stable(a_reg))
        else $error("register A changed on a flagged error");

endmodule

`default_nettype wire
